[rtl/dnu_pkg.sv]
// ----------------------------------------------------------------------------
// dnu_pkg
// Shared types and constants for the DN attribute value unescape block.
// ----------------------------------------------------------------------------
package dnu_pkg;

   localparam int DEF_MAX_VALUE_LENGTH = 4096;
   localparam int DEF_MAX_HELD_SPACES  = 15;

   localparam int BYTE_W     = 8;
   localparam int START_W    = 12;
   localparam int POS_W      = 13;
   localparam int STATUS_W   = 3;
   // flush count field wide enough for the largest allowed held-space bound
   localparam int HELD_CNT_W = 6;

   localparam logic [POS_W-1:0] POS_MAX = 13'h1FFF;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // end report status codes
   localparam logic [STATUS_W-1:0] ST_INPUT_END = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DELIM     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_ESC   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_LEADING   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

   // one parsed item: flush held spaces, then an optional byte, then an optional end
   typedef struct packed {
      logic [HELD_CNT_W-1:0] flush_cnt;
      logic                  has_data;
      logic [BYTE_W-1:0]     data;
      logic                  has_end;
      logic [STATUS_W-1:0]   status;
      logic [POS_W-1:0]      end_offset;
   } cmd_type;

endpackage

[rtl/dnu_front.sv]
// ----------------------------------------------------------------------------
// dnu_front
// Parses one raw byte per beat and turns it into a result command when the byte yields one.
// ----------------------------------------------------------------------------
module dnu_front
   import dnu_pkg::*;
#(
   parameter int MAX_VALUE_LENGTH = DEF_MAX_VALUE_LENGTH,
   parameter int MAX_HELD_SPACES  = DEF_MAX_HELD_SPACES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_accept,
   input  logic [BYTE_W-1:0]  data_byte,
   input  logic [START_W-1:0] start_offset,
   input  logic               last,
   output logic               cmd_valid,
   output cmd_type            cmd
);

   localparam int LEN_W  = $clog2(MAX_VALUE_LENGTH + 1);
   localparam int HELD_W = $clog2(MAX_HELD_SPACES + 1);
   localparam int SUM_W  = ((LEN_W > START_W) ? LEN_W : START_W) + 1;

   localparam logic [2:0] PH_FIRST  = 3'd0;
   localparam logic [2:0] PH_NORMAL = 3'd1;
   localparam logic [2:0] PH_ESC    = 3'd2;
   localparam logic [2:0] PH_HEX    = 3'd3;
   localparam logic [2:0] PH_DRAIN  = 3'd4;

   localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
   localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;

   function automatic logic [4:0] hex_of(input logic [BYTE_W-1:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r = {1'b1, 4'(c[2:0] + 3'd1) + 4'd8};
      end
      return r;
   endfunction

   function automatic logic is_special(input logic [BYTE_W-1:0] c);
      return c == 8'h20 || c == 8'h22 || c == 8'h23 || c == 8'h2B || c == 8'h2C ||
             c == 8'h3B || c == 8'h3C || c == 8'h3D || c == 8'h3E || c == 8'h7C ||
             c == 8'h5C;
   endfunction

   function automatic logic is_delim(input logic [BYTE_W-1:0] c);
      return c == 8'h22 || c == 8'h2B || c == 8'h2C || c == 8'h3B ||
             c == 8'h3C || c == 8'h3E || c == 8'h00;
   endfunction

   logic [2:0]         phase_ff, phase_in;
   logic [3:0]         hex_ff, hex_in;
   logic [HELD_W-1:0]  held_ff, held_in;
   logic [START_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [POS_W-1:0]   esc_ff, esc_in;

   logic               first;
   logic [START_W-1:0] pos_base;
   logic [LEN_W-1:0]   len_base, len_adv;
   logic [HELD_W-1:0]  held_base;
   logic [3:0]         hex_base;
   logic [SUM_W-1:0]   sum_cur, sum_adv;
   logic [POS_W-1:0]   cur_pos, adv_pos;
   logic [4:0]         hex_dec;

   logic               do_normal, do_data, emit_end, emit_data;
   logic [BYTE_W-1:0]  data_val;
   logic [HELD_W-1:0]  flush;
   logic [STATUS_W-1:0] status;
   logic [POS_W-1:0]   end_raw;
   logic [HELD_W-1:0]  end_sub;

   assign first     = (phase_ff == PH_FIRST);
   assign pos_base  = first ? start_offset : pos_ff;
   assign len_base  = first ? '0 : len_ff;
   assign held_base = first ? '0 : held_ff;
   assign hex_base  = first ? 4'd0 : hex_ff;
   assign len_adv   = (len_base < LEN_W'(MAX_VALUE_LENGTH)) ?
                      LEN_W'(len_base + LEN_W'(1)) : len_base;
   assign sum_cur   = SUM_W'(pos_base) + SUM_W'(len_base);
   assign sum_adv   = SUM_W'(pos_base) + SUM_W'(len_adv);
   assign cur_pos   = (sum_cur > SUM_W'(POS_MAX)) ? POS_MAX : sum_cur[POS_W-1:0];
   assign adv_pos   = (sum_adv > SUM_W'(POS_MAX)) ? POS_MAX : sum_adv[POS_W-1:0];
   assign hex_dec   = hex_of(data_byte);

   always_comb begin
      phase_in  = phase_ff;
      hex_in    = hex_base;
      held_in   = held_base;
      pos_in    = pos_base;
      len_in    = len_base;
      esc_in    = esc_ff;
      do_normal = 1'b0;
      do_data   = 1'b0;
      emit_data = 1'b0;
      emit_end  = 1'b0;
      data_val  = data_byte;
      flush     = '0;
      status    = ST_INPUT_END;
      end_raw   = cur_pos;
      end_sub   = '0;

      case (phase_ff)
         PH_FIRST: begin
            if (data_byte == CH_HASH || data_byte == CH_SPACE) begin
               emit_end = 1'b1;
               status   = ST_LEADING;
               end_raw  = POS_W'(start_offset);
               phase_in = last ? PH_FIRST : PH_DRAIN;
            end else begin
               do_normal = 1'b1;
            end
         end
         PH_NORMAL: begin
            do_normal = 1'b1;
         end
         PH_ESC: begin
            if (is_special(data_byte)) begin
               do_data = 1'b1;
            end else if (hex_dec[4] && !last) begin
               hex_in   = hex_dec[3:0];
               len_in   = len_adv;
               phase_in = PH_HEX;
            end else begin
               emit_end = 1'b1;
               status   = ST_BAD_ESC;
               end_raw  = esc_ff;
               end_sub  = held_base;
               held_in  = '0;
               phase_in = last ? PH_FIRST : PH_DRAIN;
            end
         end
         PH_HEX: begin
            if (hex_dec[4]) begin
               do_data  = 1'b1;
               data_val = {hex_base, hex_dec[3:0]};
            end else begin
               emit_end = 1'b1;
               status   = ST_BAD_ESC;
               end_raw  = esc_ff;
               end_sub  = held_base;
               held_in  = '0;
               phase_in = last ? PH_FIRST : PH_DRAIN;
            end
         end
         PH_DRAIN: begin
            if (last) begin
               phase_in = PH_FIRST;
            end
         end
         default: begin
            phase_in = PH_FIRST;
         end
      endcase

      if (do_normal) begin
         if (data_byte == CH_BSLASH) begin
            esc_in   = cur_pos;
            len_in   = len_adv;
            phase_in = PH_ESC;
            if (last) begin
               emit_end = 1'b1;
               status   = ST_BAD_ESC;
               end_sub  = held_base;
               held_in  = '0;
               phase_in = PH_FIRST;
            end
         end else if (is_delim(data_byte)) begin
            emit_end = 1'b1;
            status   = ST_DELIM;
            end_sub  = held_base;
            held_in  = '0;
            phase_in = last ? PH_FIRST : PH_DRAIN;
         end else if (data_byte == CH_SPACE) begin
            if (held_base >= HELD_W'(MAX_HELD_SPACES)) begin
               emit_end = 1'b1;
               status   = ST_OVERFLOW;
               end_sub  = held_base;
               held_in  = '0;
               phase_in = last ? PH_FIRST : PH_DRAIN;
            end else begin
               held_in = HELD_W'(held_base + HELD_W'(1));
               len_in  = len_adv;
               if (last) begin
                  // trailing run is dropped from the reported length
                  emit_end = 1'b1;
                  status   = ST_INPUT_END;
                  end_raw  = adv_pos;
                  end_sub  = HELD_W'(held_base + HELD_W'(1));
                  held_in  = '0;
                  phase_in = PH_FIRST;
               end
            end
         end else begin
            do_data = 1'b1;
         end
      end

      if (do_data) begin
         emit_data = 1'b1;
         flush     = held_base;
         held_in   = '0;
         len_in    = len_adv;
         phase_in  = PH_NORMAL;
         if (last) begin
            emit_end = 1'b1;
            status   = ST_INPUT_END;
            end_raw  = adv_pos;
            end_sub  = '0;
            phase_in = PH_FIRST;
         end
      end
   end

   assign cmd_valid      = emit_data | emit_end;
   assign cmd.flush_cnt  = HELD_CNT_W'(flush);
   assign cmd.has_data   = emit_data;
   assign cmd.data       = data_val;
   assign cmd.has_end    = emit_end;
   assign cmd.status     = status;
   assign cmd.end_offset = (end_raw >= POS_W'(end_sub)) ? POS_W'(end_raw - POS_W'(end_sub)) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         hex_ff   <= '0;
         held_ff  <= '0;
         pos_ff   <= '0;
         len_ff   <= '0;
         esc_ff   <= '0;
      end else if (in_accept) begin
         phase_ff <= phase_in;
         hex_ff   <= hex_in;
         held_ff  <= held_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         esc_ff   <= esc_in;
      end
   end

endmodule

[rtl/dnu_queue.sv]
// ----------------------------------------------------------------------------
// dnu_queue
// Short command queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module dnu_queue
   import dnu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type wdata,
   output logic    full,
   input  logic    pop,
   output cmd_type rdata,
   output logic    empty
);

   cmd_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = entries_ff[rd_ptr_ff];

   assign wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + QPTR_W'(1)) : wr_ptr_ff;
   assign rd_ptr_in = do_pop  ? QPTR_W'(rd_ptr_ff + QPTR_W'(1)) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = (QPTR_W+1)'(count_ff + (QPTR_W+1)'(1));
      end else if (do_pop && !do_push) begin
         count_in = (QPTR_W+1)'(count_ff - (QPTR_W+1)'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/dnu_back.sv]
// ----------------------------------------------------------------------------
// dnu_back
// Expands the queued command into result beats: spaces, byte, end report.
// ----------------------------------------------------------------------------
module dnu_back
   import dnu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             head,
   input  logic                head_empty,
   output logic                head_pop,
   input  logic                rsp_pop,
   output logic                rsp_result_kind,
   output logic [BYTE_W-1:0]   rsp_out_byte,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [POS_W-1:0]    rsp_end_offset,
   output logic                rsp_last_of_run
);

   logic [HELD_CNT_W-1:0] sp_cnt_ff, sp_cnt_in;
   logic                  data_done_ff, data_done_in;
   logic                  in_spaces, in_data, is_final, take;
   logic [HELD_CNT_W-1:0] sp_next;

   assign sp_next   = HELD_CNT_W'(sp_cnt_ff + HELD_CNT_W'(1));
   assign in_spaces = (sp_cnt_ff < head.flush_cnt);
   assign in_data   = !in_spaces && head.has_data && !data_done_ff;
   assign take      = rsp_pop && !head_empty;

   always_comb begin
      if (in_spaces) begin
         is_final = (sp_next == head.flush_cnt) && !head.has_data && !head.has_end;
      end else if (in_data) begin
         is_final = !head.has_end;
      end else begin
         is_final = 1'b1;
      end
   end

   assign rsp_result_kind = !(in_spaces || in_data);
   assign rsp_out_byte    = in_spaces ? CH_SPACE : (in_data ? head.data : '0);
   assign rsp_status      = rsp_result_kind ? head.status : ST_INPUT_END;
   assign rsp_end_offset  = rsp_result_kind ? head.end_offset : '0;
   assign rsp_last_of_run = is_final;
   assign head_pop        = take && is_final;

   always_comb begin
      sp_cnt_in    = sp_cnt_ff;
      data_done_in = data_done_ff;
      if (take) begin
         if (is_final) begin
            sp_cnt_in    = '0;
            data_done_in = 1'b0;
         end else if (in_spaces) begin
            sp_cnt_in = sp_next;
         end else begin
            data_done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_cnt_ff    <= '0;
         data_done_ff <= 1'b0;
      end else begin
         sp_cnt_ff    <= sp_cnt_in;
         data_done_ff <= data_done_in;
      end
   end

endmodule

[rtl/dn_value_unescape_top.sv]
// ----------------------------------------------------------------------------
// dn_value_unescape_top
// Streaming unescape of one distinguished-name attribute value per run.
//
//   channel  | handshake        | beat contents
//   ---------+------------------+-------------------------------------------
//   req_     | push / full      | data_byte, start_offset, last
//   rsp_     | pop / empty      | result_kind, out_byte, status, end_offset,
//            |                  | last_of_run
//
// One input beat is taken per cycle while the command queue has room.
// Results leave one per cycle while the receiver pops; an input beat can release up to
// MAX_HELD_SPACES + 2 results, and the 4-entry command queue absorbs these
// bursts until it fills, then full holds the input side.
// A result is registered in the command queue, behind any waiting results, before it shows on rsp_.
// Reset is synchronous; there is no clearing sweep.
// ----------------------------------------------------------------------------
module dn_value_unescape_top
   import dnu_pkg::*;
#(
   parameter int MAX_VALUE_LENGTH = DEF_MAX_VALUE_LENGTH,
   parameter int MAX_HELD_SPACES  = DEF_MAX_HELD_SPACES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic [START_W-1:0]  req_start_offset,
   input  logic                req_last,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic                rsp_result_kind,
   output logic [BYTE_W-1:0]   rsp_out_byte,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [POS_W-1:0]    rsp_end_offset,
   output logic                rsp_last_of_run
);

   logic    in_accept, cmd_valid, q_full, q_empty, q_pop;
   cmd_type cmd, head;

   assign in_accept = req_push && !q_full;
   assign req_full  = q_full;
   assign rsp_empty = q_empty;

   dnu_front #(
      .MAX_VALUE_LENGTH (MAX_VALUE_LENGTH),
      .MAX_HELD_SPACES  (MAX_HELD_SPACES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_accept    (in_accept),
      .data_byte    (req_data_byte),
      .start_offset (req_start_offset),
      .last         (req_last),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd)
   );

   dnu_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (in_accept && cmd_valid),
      .wdata (cmd),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (head),
      .empty (q_empty)
   );

   dnu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .head_empty      (q_empty),
      .head_pop        (q_pop),
      .rsp_pop         (rsp_pop),
      .rsp_result_kind (rsp_result_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_status      (rsp_status),
      .rsp_end_offset  (rsp_end_offset),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

[rtl/dnu_checker.sv]
// ----------------------------------------------------------------------------
// dnu_checker
// Port-level checks on the unescape block's result stream.
// ----------------------------------------------------------------------------
module dnu_checker
   import dnu_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_empty,
   input logic                rsp_pop,
   input logic                rsp_result_kind,
   input logic [BYTE_W-1:0]   rsp_out_byte,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [POS_W-1:0]    rsp_end_offset,
   input logic                rsp_last_of_run
);

   // a waiting beat that is not popped holds its contents
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_result_kind) &&
         $stable(rsp_out_byte) && $stable(rsp_status) && $stable(rsp_end_offset) &&
         $stable(rsp_last_of_run)))
      else $error("result beat changed while stalled");

   // end report always closes the run of results of its input beat
   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_result_kind) |-> rsp_last_of_run)
      else $error("end report without last_of_run");

   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_result_kind) |-> (rsp_status == ST_INPUT_END &&
         rsp_end_offset == '0))
      else $error("data beat carries end fields");

   a_end_clean: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_result_kind) |-> (rsp_out_byte == '0))
      else $error("end report carries a byte");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("results left after reset");

endmodule

bind dn_value_unescape_top dnu_checker u_checker (.*);

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the DN attribute value unescape block. Raw value
// bytes go in through the push/full queue port, and decoded bytes and end
// reports come back through the empty/pop queue port. A scoreboard class
// tracks the decoder state for every accepted beat and checks each popped
// result, field by field, against the oldest expected one. The stimulus is a
// short directed set, then one longer value, then random values. Most
// random values are well formed; the rest are broken values and raw noise.
// Both sides idle at random. The receiver holds off once for a long stretch
// so that the block backs up and asserts full.
// ----------------------------------------------------------------------------
module tb;
   import dnu_pkg::*;

   localparam int MAX_LEN   = DEF_MAX_VALUE_LENGTH;
   localparam int MAX_HELD  = DEF_MAX_HELD_SPACES;
   localparam int NUM_ITEMS = 420;
   localparam int LONG_LEN  = 48;

   localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;

   typedef enum logic [2:0] {
      P_AWAIT_FIRST,
      P_TEXT,
      P_ESCAPE,
      P_HEX_LOW,
      P_SKIP
   } parse_phase_type;

   typedef struct packed {
      logic                kind;
      logic [BYTE_W-1:0]   data;
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    end_off;
      logic                run_last;
   } rsp_beat_type;

   class unescape_scoreboard;
      rsp_beat_type    expected_q[$];
      int              errors;
      parse_phase_type phase;
      logic [3:0]      hi_nib;
      int              held;
      int              base_pos;
      int              esc_pos;
      int              vlen;

      function new();
         expected_q.delete();
         errors   = 0;
         phase    = P_AWAIT_FIRST;
         hi_nib   = 4'd0;
         held     = 0;
         base_pos = 0;
         esc_pos  = 0;
         vlen     = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function bit is_special(logic [7:0] c);
         return c == CH_SPACE || c == "\"" || c == CH_HASH || c == "+" || c == "," ||
                c == ";" || c == "<" || c == "=" || c == ">" || c == "|" || c == CH_BSLASH;
      endfunction

      function bit is_delim(logic [7:0] c);
         return c == "\"" || c == "+" || c == "," || c == ";" || c == "<" ||
                c == ">" || c == 8'h00;
      endfunction

      // 16 means not a hex digit
      function int hex_val(logic [7:0] c);
         if (c >= "0" && c <= "9") return c - "0";
         if (c >= "A" && c <= "F") return c - "A" + 10;
         if (c >= "a" && c <= "f") return c - "a" + 10;
         return 16;
      endfunction

      function int cur_pos();
         int p;
         p = base_pos + vlen;
         return (p > POS_MAX) ? int'(POS_MAX) : p;
      endfunction

      function int minus_held(int p);
         return (p >= held) ? p - held : 0;
      endfunction

      function void grow();
         if (vlen < MAX_LEN) vlen++;
      endfunction

      function void push_rsp(logic k, logic [7:0] b, logic [2:0] st, int e);
         rsp_beat_type r;
         r.kind     = k;
         r.data     = b;
         r.status   = st;
         r.end_off  = e[POS_W-1:0];
         r.run_last = 1'b0;
         expected_q.push_back(r);
      endfunction

      function void finish_value(logic [2:0] st, int e, logic l);
         push_rsp(1'b1, 8'h00, st, e);
         held  = 0;
         phase = l ? P_AWAIT_FIRST : P_SKIP;
      endfunction

      // release held spaces ahead of a decoded byte
      function void emit_data(logic [7:0] c, logic l);
         repeat (held) push_rsp(1'b0, CH_SPACE, ST_INPUT_END, 0);
         held = 0;
         push_rsp(1'b0, c, ST_INPUT_END, 0);
         grow();
         phase = P_TEXT;
         if (l) finish_value(ST_INPUT_END, cur_pos(), 1'b1);
      endfunction

      function void text_byte(logic [7:0] c, logic l);
         int p;
         p = cur_pos();
         if (c == CH_BSLASH) begin
            esc_pos = p;
            grow();
            phase = P_ESCAPE;
            if (l) finish_value(ST_BAD_ESC, minus_held(p), 1'b1);
         end else if (is_delim(c)) begin
            finish_value(ST_DELIM, minus_held(p), l);
         end else if (c == CH_SPACE) begin
            if (held >= MAX_HELD) begin
               finish_value(ST_OVERFLOW, minus_held(p), l);
            end else begin
               held++;
               grow();
               if (l) finish_value(ST_INPUT_END, minus_held(cur_pos()), 1'b1);
            end
         end else begin
            emit_data(c, l);
         end
      endfunction

      function void note_beat(logic [7:0] c, logic [11:0] s, logic l);
         int           n0;
         int           h;
         rsp_beat_type r;
         n0 = expected_q.size();
         case (phase)
            P_AWAIT_FIRST: begin
               base_pos = s;
               vlen     = 0;
               held     = 0;
               hi_nib   = 4'd0;
               if (c == CH_HASH || c == CH_SPACE) finish_value(ST_LEADING, s, l);
               else text_byte(c, l);
            end
            P_TEXT: text_byte(c, l);
            P_ESCAPE: begin
               h = hex_val(c);
               if (is_special(c)) begin
                  emit_data(c, l);
               end else if (h < 16 && !l) begin
                  hi_nib = h[3:0];
                  grow();
                  phase = P_HEX_LOW;
               end else begin
                  finish_value(ST_BAD_ESC, minus_held(esc_pos), l);
               end
            end
            P_HEX_LOW: begin
               h = hex_val(c);
               if (h < 16) emit_data({hi_nib, h[3:0]}, l);
               else finish_value(ST_BAD_ESC, minus_held(esc_pos), l);
            end
            default: if (l) phase = P_AWAIT_FIRST;
         endcase
         // flag the final result of this beat
         if (expected_q.size() > n0) begin
            r = expected_q.pop_back();
            r.run_last = 1'b1;
            expected_q.push_back(r);
         end
      endfunction

      function void cmp(string name, logic [15:0] e, logic [15:0] g);
         if (g !== e) begin
            $error("%s: expected %0d, got %0d", name, e, g);
            errors++;
         end
      endfunction

      function void check_result(logic k, logic [7:0] b, logic [2:0] st,
                                 logic [12:0] e, logic l);
         rsp_beat_type r;
         if (expected_q.size() == 0) begin
            $error("result with nothing expected: kind %0d byte %0h status %0d", k, b, st);
            errors++;
            return;
         end
         r = expected_q.pop_front();
         cmp("result_kind", r.kind, k);
         cmp("out_byte", r.data, b);
         cmp("status", r.status, st);
         cmp("end_offset", r.end_off, e);
         cmp("last_of_run", r.run_last, l);
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   logic                req_full;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic [START_W-1:0]  req_start_offset = '0;
   logic                req_last = 1'b0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   logic                rsp_result_kind;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic [STATUS_W-1:0] rsp_status;
   logic [POS_W-1:0]    rsp_end_offset;
   logic                rsp_last_of_run;

   unescape_scoreboard sb = new();

   bit calm        = 1'b0;
   bit squeeze_req = 1'b0;
   int beats_sent  = 0;

   string plain_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_.~=#|";
   string esc_set   = " \"#+,;<=>|\\";
   string delim_set = "\"+,;<>";
   string bad_set   = "gGzZ!%xQ";

   dn_value_unescape_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_start_offset (req_start_offset),
      .req_last         (req_last),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_status       (rsp_status),
      .rsp_end_offset   (rsp_end_offset),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [7:0] pick_plain();
      if ($urandom_range(0, 3) == 0) return 8'($urandom_range(128, 255));
      return plain_set[$urandom_range(0, plain_set.len() - 1)];
   endfunction

   function automatic logic [7:0] hex_ch(logic [3:0] nib, bit lower);
      string      digits;
      logic [7:0] c;
      digits = "0123456789ABCDEF";
      c = digits[nib];
      if (lower && nib > 4'd9) c = c + 8'h20;
      return c;
   endfunction

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic drive_beat(logic [7:0] d, logic [11:0] s, logic l);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push         <= 1'b1;
      req_data_byte    <= d;
      req_start_offset <= s;
      req_last         <= l;
      forever begin
         @(posedge clock);
         if (!req_full) break;
      end
      sb.note_beat(d, s, l);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic send_str(string s, logic [11:0] start);
      for (int i = 0; i < s.len(); i++) drive_beat(s[i], start, i == s.len() - 1);
   endtask

   task automatic send_random_value();
      logic [7:0]  q[$];
      logic [7:0]  v;
      logic [11:0] start;
      int          kind;
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 5))
         0: start = 12'd0;
         1: start = 12'hFFF;
         default: start = 12'($urandom_range(0, 4095));
      endcase
      if (kind < 70) begin
         // mostly well formed: text, space runs (some past the held-space bound), escapes, maybe trailing spaces
         if ($urandom_range(0, 4) == 0) begin
            q.push_back(CH_BSLASH);
            q.push_back(esc_set[$urandom_range(0, esc_set.len() - 1)]);
         end else begin
            q.push_back(pick_plain());
         end
         repeat ($urandom_range(0, 10)) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
               q.push_back(pick_plain());
            end else if (kind < 55) begin
               repeat ($urandom_range(1, 3)) q.push_back(CH_SPACE);
            end else if (kind < 60) begin
               repeat ($urandom_range(13, 17)) q.push_back(CH_SPACE);
            end else if (kind < 75) begin
               q.push_back(CH_BSLASH);
               q.push_back(esc_set[$urandom_range(0, esc_set.len() - 1)]);
            end else begin
               v = 8'($urandom_range(0, 255));
               q.push_back(CH_BSLASH);
               q.push_back(hex_ch(v[7:4], 1'($urandom_range(0, 1))));
               q.push_back(hex_ch(v[3:0], 1'($urandom_range(0, 1))));
            end
         end
         if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) q.push_back(CH_SPACE);
      end else if (kind < 88) begin
         // broken: a stop of some kind, then bytes to skip
         repeat ($urandom_range(0, 3)) q.push_back(pick_plain());
         case ($urandom_range(0, 4))
            0: q.push_back(($urandom_range(0, 6) == 6) ? 8'h00 :
                           delim_set[$urandom_range(0, delim_set.len() - 1)]);
            1: begin
               q.push_back(CH_BSLASH);
               q.push_back(bad_set[$urandom_range(0, bad_set.len() - 1)]);
            end
            2: q.push_back(CH_BSLASH);
            3: begin
               q.push_back(CH_BSLASH);
               q.push_back(hex_ch(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
            end
            default: begin
               q.delete();
               q.push_back($urandom_range(0, 1) ? CH_HASH : CH_SPACE);
            end
         endcase
         repeat ($urandom_range(0, 4)) q.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
      end
      for (int i = 0; i < q.size(); i++) drive_beat(q[i], start, i == q.size() - 1);
   endtask

   // sample accepted results
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         sb.check_result(rsp_result_kind, rsp_out_byte, rsp_status, rsp_end_offset,
                         rsp_last_of_run);
   end

   // receiver: random pops, plus one long hold-off on request
   initial begin
      int stall_left;
      int gap;
      stall_left = 0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (squeeze_req) begin
            stall_left  = 120;
            squeeze_req = 1'b0;
         end
         if (stall_left > 0) begin
            rsp_pop <= 1'b0;
            stall_left--;
         end else begin
            gap = pick_gap();
            if (gap == 0) begin
               rsp_pop <= 1'b1;
            end else begin
               rsp_pop <= 1'b0;
               stall_left = gap - 1;
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed values
      send_str("#", 12'd0);
      send_str(" ", 12'hFFF);
      send_str("a \\4A\\6f  ", 12'hFFF);
      send_str("b;c", 12'd12);
      send_str("\\", 12'd5);
      send_str("\\4", 12'd6);
      send_str("\\g", 12'd7);
      send_str("\\4z", 12'd8);
      send_str("\\+", 12'd9);
      drive_beat(8'h00, 12'd7, 1'b1);

      // one longer value, ending in dropped spaces
      calm = 1'b1;
      for (int i = 0; i < LONG_LEN; i++)
         drive_beat((i >= LONG_LEN - 2) ? CH_SPACE : 8'h6B, 12'd100, i == LONG_LEN - 1);
      calm = 1'b0;

      // random values; hold the receiver off early so the block backs up
      squeeze_req = 1'b1;
      while (beats_sent < NUM_ITEMS) begin
         calm = ($urandom_range(0, 4) == 0);
         send_random_value();
      end
      calm = 1'b0;
      req_push <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   initial begin
      #160000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

[files.f]
rtl/dnu_pkg.sv
rtl/dnu_front.sv
rtl/dnu_queue.sv
rtl/dnu_back.sv
rtl/dn_value_unescape_top.sv
rtl/dnu_checker.sv
dv/tb.sv
